// File: hw/rtl/cks_pkg.sv
// cks_pkg: shared types and constants for the composite key rank sorter
// used by cks_cmp and composite_key_rank_sorter; no dependencies
package cks_pkg;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic                     is_primary;
    logic signed [DATA_W-1:0] left_edge;
    logic signed [DATA_W-1:0] top_edge;
    logic        [DATA_W-1:0] handle_id;
    logic                     last_record;
  } in_item_t;

  typedef struct packed {
    logic                     out_primary;
    logic signed [DATA_W-1:0] out_left;
    logic signed [DATA_W-1:0] out_top;
    logic        [DATA_W-1:0] out_handle;
    logic                     out_last;
  } out_item_t;

  // one stored record as held in the record memories
  typedef struct packed {
    logic                     primary;
    logic signed [DATA_W-1:0] left_pos;
    logic signed [DATA_W-1:0] top_pos;
    logic        [DATA_W-1:0] handle;
  } rec_t;

  localparam int KEY_W = 1 + 3 * DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_RANK_DRAIN,
    ST_EMIT,
    ST_EMIT_DRAIN
  } state_t;

endpackage

// File: hw/rtl/composite_key_rank_sorter.sv
// composite_key_rank_sorter: top level, record store, rank sequencer and emitter
// depends on cks_pkg, cks_ram, cks_cmp
//
// Usage: records are offered on in_item with start; a transfer happens when start
// is high and busy is low. Up to MAX_ENTRIES records are kept, further ones are
// dropped. Busy stays low while records are stored. A record with
// last_record set starts the sort: busy rises and the block takes nothing more.
// Ranking runs one shared comparator over all n*n record pairs, one pair per
// cycle from a two port read of the record store. Emission then walks the ranks
// 0..highest, one per cycle, through the rank-to-record table; results appear on
// out_item with out_valid high for one cycle each, out_last marking the final
// one. Ranks held by no record (exact duplicates) leave a gap in the results.
// The receiver cannot stall results. Reset empties the store and returns the
// sequencer to idle; afterwards a new set begins.
module composite_key_rank_sorter #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  cks_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output cks_pkg::out_item_t out_item
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int RW = $bits(cks_pkg::rec_t);

  cks_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] max_rank_r, max_rank_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic          cmp_last_r, cmp_last_nxt;
  logic [IW-1:0] cmp_j_r, cmp_j_nxt;
  logic [IW-1:0] r_r, r_nxt;
  logic          sa_v_r, sa_v_nxt;
  logic          sa_ok_r, sa_ok_nxt;
  logic          sa_last_r, sa_last_nxt;
  logic          sb_v_r, sb_v_nxt;
  logic          sb_last_r, sb_last_nxt;
  logic          valid_r   [MAX_ENTRIES];
  logic          valid_nxt [MAX_ENTRIES];

  logic          in_acc;
  logic          store_we;
  logic          set_start;
  logic          rank_issue;
  logic          emit_issue;
  logic          emit_done;
  logic [IW-1:0] last_idx;
  logic [IW:0]   rank_sum;
  logic [IW-1:0] rank_now;
  logic          idx_we;
  logic          a_first;

  cks_pkg::rec_t wr_rec;
  cks_pkg::rec_t rd_a;
  cks_pkg::rec_t rd_b;
  logic [RW-1:0] rd_a_bits;
  logic [RW-1:0] rd_b_bits;
  logic [IW-1:0] raddr_a;
  logic [IW-1:0] idx_rd;

  assign in_acc    = start & ~busy;
  assign store_we  = in_acc & (count_r != CW'(MAX_ENTRIES));
  assign set_start = in_acc & in_item.last_record;
  assign last_idx  = IW'(count_r - CW'(1));
  assign emit_done = (state_r == cks_pkg::ST_EMIT_DRAIN) & ~sa_v_r & ~sb_v_r;

  assign wr_rec.primary  = in_item.is_primary;
  assign wr_rec.left_pos = in_item.left_edge;
  assign wr_rec.top_pos  = in_item.top_edge;
  assign wr_rec.handle   = in_item.handle_id;

  // port a reads record i while ranking and the emitted record afterwards
  assign raddr_a = rank_issue ? i_r : idx_rd;

  cks_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_rec_a (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[IW-1:0]),
    .wdata (wr_rec),
    .raddr (raddr_a),
    .rdata (rd_a_bits)
  );

  cks_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_rec_b (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[IW-1:0]),
    .wdata (wr_rec),
    .raddr (j_r),
    .rdata (rd_b_bits)
  );

  // rank to first record index
  cks_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_rank_idx (
    .clk   (clk),
    .we    (idx_we),
    .waddr (rank_now),
    .wdata (cmp_j_r),
    .raddr (r_r),
    .rdata (idx_rd)
  );

  assign rd_a = rd_a_bits;
  assign rd_b = rd_b_bits;

  cks_cmp u_cmp (
    .rec_a   (rd_a),
    .rec_b   (rd_b),
    .a_first (a_first)
  );

  assign rank_sum = {1'b0, cnt_r} + (IW + 1)'(a_first);
  assign rank_now = rank_sum[IW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cks_pkg::ST_IDLE: begin
        if (set_start) state_nxt = cks_pkg::ST_RANK;
      end
      cks_pkg::ST_RANK: begin
        if ((i_r == last_idx) && (j_r == last_idx)) state_nxt = cks_pkg::ST_RANK_DRAIN;
      end
      cks_pkg::ST_RANK_DRAIN: begin
        state_nxt = cks_pkg::ST_EMIT;
      end
      cks_pkg::ST_EMIT: begin
        if (r_r == max_rank_r) state_nxt = cks_pkg::ST_EMIT_DRAIN;
      end
      cks_pkg::ST_EMIT_DRAIN: begin
        if (~sa_v_r && ~sb_v_r) state_nxt = cks_pkg::ST_IDLE;
      end
      default: state_nxt = cks_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy       = 1'b1;
    rank_issue = 1'b0;
    emit_issue = 1'b0;
    unique case (state_r)
      cks_pkg::ST_IDLE:       busy = 1'b0;
      cks_pkg::ST_RANK:       rank_issue = 1'b1;
      cks_pkg::ST_RANK_DRAIN: ;
      cks_pkg::ST_EMIT:       emit_issue = 1'b1;
      cks_pkg::ST_EMIT_DRAIN: ;
      default:                busy = 1'b1;
    endcase
  end

  // datapath next values
  always_comb begin
    count_nxt    = count_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    cnt_nxt      = cnt_r;
    max_rank_nxt = max_rank_r;
    cmp_j_nxt    = j_r;
    cmp_last_nxt = (i_r == last_idx);
    cmp_v_nxt    = rank_issue;
    r_nxt        = r_r;
    sa_v_nxt     = emit_issue;
    sa_ok_nxt    = valid_r[r_r];
    sa_last_nxt  = (r_r == max_rank_r);
    sb_v_nxt     = sa_v_r & sa_ok_r;
    sb_last_nxt  = sa_last_r;
    idx_we       = 1'b0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      valid_nxt[k] = valid_r[k];
    end

    if (store_we) count_nxt = count_r + CW'(1);
    if (emit_done) count_nxt = '0;

    if (set_start) begin
      i_nxt        = '0;
      j_nxt        = '0;
      cnt_nxt      = '0;
      max_rank_nxt = '0;
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        valid_nxt[k] = 1'b0;
      end
    end

    if (rank_issue) begin
      if (i_r == last_idx) begin
        i_nxt = '0;
        j_nxt = j_r + IW'(1);
      end else begin
        i_nxt = i_r + IW'(1);
      end
    end

    // one pair result per cycle; the pair with the last i closes the rank of j
    if (cmp_v_r) begin
      if (cmp_last_r) begin
        cnt_nxt = '0;
        if (!valid_r[rank_now]) begin
          valid_nxt[rank_now] = 1'b1;
          idx_we              = 1'b1;
        end
        if (rank_sum > {1'b0, max_rank_r}) max_rank_nxt = rank_now;
      end else begin
        cnt_nxt = rank_now;
      end
    end

    if (state_r == cks_pkg::ST_RANK_DRAIN) r_nxt = '0;
    if (emit_issue) r_nxt = r_r + IW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cks_pkg::ST_IDLE;
      count_r <= '0;
      cmp_v_r <= 1'b0;
      sa_v_r  <= 1'b0;
      sb_v_r  <= 1'b0;
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cmp_v_r <= cmp_v_nxt;
      sa_v_r  <= sa_v_nxt;
      sb_v_r  <= sb_v_nxt;
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        valid_r[k] <= valid_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    cnt_r      <= cnt_nxt;
    max_rank_r <= max_rank_nxt;
    cmp_last_r <= cmp_last_nxt;
    cmp_j_r    <= cmp_j_nxt;
    r_r        <= r_nxt;
    sa_ok_r    <= sa_ok_nxt;
    sa_last_r  <= sa_last_nxt;
    sb_last_r  <= sb_last_nxt;
  end

  assign out_valid            = sb_v_r;
  assign out_item.out_primary = rd_a.primary;
  assign out_item.out_left    = rd_a.left_pos;
  assign out_item.out_top     = rd_a.top_pos;
  assign out_item.out_handle  = rd_a.handle;
  assign out_item.out_last    = sb_last_r;

  a_out_in_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result transfer outside a sort");

  a_last_ends : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.out_last) |=> !out_valid)
    else $error("result after the final one");

  a_rank_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cks_pkg::ST_RANK) |-> (count_r != '0))
    else $error("ranking an empty set");

  a_rank_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (cmp_v_r && cmp_last_r) |-> ((CW + 1)'(rank_sum) < (CW + 1)'(count_r)))
    else $error("rank beyond record count");

endmodule

// File: hw/rtl/cks_ram.sv
// cks_ram: generic single write port, single read port ram with registered read
// no dependencies
module cks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/cks_cmp.sv
// cks_cmp: composite key comparator, primary first, then signed left, signed top, handle
// depends on cks_pkg
module cks_cmp (
  input  cks_pkg::rec_t rec_a,
  input  cks_pkg::rec_t rec_b,
  output logic          a_first
);

  logic [cks_pkg::KEY_W-1:0] key_a;
  logic [cks_pkg::KEY_W-1:0] key_b;

  // inverted primary flag and flipped sign bits turn the order into one unsigned compare
  assign key_a = {~rec_a.primary,
                  ~rec_a.left_pos[cks_pkg::DATA_W-1], rec_a.left_pos[cks_pkg::DATA_W-2:0],
                  ~rec_a.top_pos[cks_pkg::DATA_W-1], rec_a.top_pos[cks_pkg::DATA_W-2:0],
                  rec_a.handle};
  assign key_b = {~rec_b.primary,
                  ~rec_b.left_pos[cks_pkg::DATA_W-1], rec_b.left_pos[cks_pkg::DATA_W-2:0],
                  ~rec_b.top_pos[cks_pkg::DATA_W-1], rec_b.top_pos[cks_pkg::DATA_W-2:0],
                  rec_b.handle};

  assign a_first = (key_a < key_b);

endmodule
